// File: rtl/core/ahts_pkg.sv
// Shared types and codes for the address hit table.
package ahts_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_SELECT = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    localparam logic [2:0] STAT_INSERTED  = 3'd0;
    localparam logic [2:0] STAT_HIT       = 3'd1;
    localparam logic [2:0] STAT_BAD_TYPE  = 3'd2;
    localparam logic [2:0] STAT_FULL      = 3'd3;
    localparam logic [2:0] STAT_FOUND     = 3'd4;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd5;
    localparam logic [2:0] STAT_SELECTED  = 3'd6;
    localparam logic [2:0] STAT_NONE      = 3'd7;

    localparam int IN_DATA_W  = 200;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 192;
    localparam int OUT_USER_W = 3;

    localparam logic [63:0] V4_HI_MASK = 64'hFFFF_FFFF_0000_0000;

    typedef struct packed {
        logic        typ;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [31:0] hits;
        logic [31:0] tick;
    } t_entry;

endpackage

// File: rtl/core/address_hit_table_select.sv
// Address hit table: add / lookup / select / clear over a slot memory.
//
// Holds TABLE_ENTRIES answer addresses (IPv4 or IPv6) with hit count and last
// receive tick in a single-port-read entry memory; valid bits sit in flops and
// clear empties the table by resetting all valid bits together. Add, lookup and
// select walk the memory one slot per cycle through its read port, then read the
// chosen slot once more. One item is worked on at a time; the next one is taken
// while a finished result still waits in the output register. IPv4 addresses are
// kept with the low 32 bits of the high word and the whole low word zeroed.
module address_hit_table_select #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // addr_hi[63:0], addr_lo[127:64], now_tick[159:128], sent_tick[191:160],
    // select_inhibit[192], zero pad [199:193]
    input  logic [ahts_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // kind[1:0], typ[2]
    input  logic [ahts_pkg::IN_USER_W-1:0]    i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // hit_count[31:0], entry_tick[63:32], sel_addr_hi[127:64], sel_addr_lo[191:128]
    output logic [ahts_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // status[2:0]
    output logic [ahts_pkg::OUT_USER_W-1:0]   o_m_tuser
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_ENTRIES);

    ahts_pkg::t_state r_state, n_state;

    // item registers
    logic [1:0]   r_kind;
    logic         r_typ;
    logic [63:0]  r_hi, r_lo;
    logic [31:0]  r_now, r_send;
    logic         r_inhibit;

    // scan trackers
    logic [CW-1:0] r_cnt;
    logic          r_found, r_free_ok, r_hit_ok, r_late_ok;
    logic [IW-1:0] r_found_idx, r_free_idx, r_hit_idx, r_late_idx;
    logic [31:0]   r_max_hit, r_max_diff;

    logic [TABLE_ENTRIES-1:0] r_valid;

    ahts_pkg::t_entry mem [TABLE_ENTRIES];
    ahts_pkg::t_entry r_rd_data;

    logic                      r_out_vld;
    logic [ahts_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [ahts_pkg::OUT_USER_W-1:0] r_out_user;

    logic          in_beat;
    logic          leave_done;
    logic [CW-1:0] ev_full;
    logic [IW-1:0] ev_idx;
    logic          ev_on, ev_valid, ev_match, ev_same;
    logic [31:0]   ev_diff;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] pick_idx;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    ahts_pkg::t_entry wr_data;
    logic [2:0]    res_stat;
    logic          res_ent;
    ahts_pkg::t_entry res_data;
    logic [31:0]   sat_hits;
    logic          set_valid, clr_all;

    assign o_s_tready = (r_state == ahts_pkg::ST_IDLE);
    assign in_beat    = i_s_tvalid && o_s_tready;
    assign leave_done = (r_state == ahts_pkg::ST_DONE) && (!r_out_vld || i_m_tready);

    assign ev_full  = r_cnt - CW'(1);
    assign ev_idx   = ev_full[IW-1:0];
    assign ev_on    = (r_state == ahts_pkg::ST_SCAN) && (r_cnt != '0);
    assign ev_valid = r_valid[ev_idx];
    assign ev_match = ev_valid && (r_rd_data.typ == r_typ);
    assign ev_same  = ev_match && (r_rd_data.hi == r_hi) && (r_rd_data.lo == r_lo);
    assign ev_diff  = r_rd_data.tick - r_send;

    assign pick_idx = (r_kind == ahts_pkg::KIND_SELECT)
                    ? ((r_hit_ok && (r_max_hit > 32'd1)) ? r_hit_idx : r_late_idx)
                    : r_found_idx;

    assign sat_hits = (r_rd_data.hits == '1) ? r_rd_data.hits : r_rd_data.hits + 32'd1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ahts_pkg::ST_IDLE: begin
                if (in_beat) begin
                    n_state = (i_s_tuser[1:0] == ahts_pkg::KIND_CLEAR)
                            ? ahts_pkg::ST_DONE : ahts_pkg::ST_SCAN;
                end
            end
            ahts_pkg::ST_SCAN: begin
                if (r_cnt == LAST_CNT) begin
                    n_state = ahts_pkg::ST_FETCH;
                end
            end
            ahts_pkg::ST_FETCH: n_state = ahts_pkg::ST_DONE;
            ahts_pkg::ST_DONE: begin
                if (leave_done) begin
                    n_state = ahts_pkg::ST_IDLE;
                end
            end
            default: n_state = ahts_pkg::ST_IDLE;
        endcase
    end

    // memory control and result forming
    always_comb begin
        rd_en     = 1'b0;
        rd_addr   = r_cnt[IW-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_found_idx;
        wr_data   = r_rd_data;
        res_stat  = ahts_pkg::STAT_NONE;
        res_ent   = 1'b0;
        res_data  = r_rd_data;
        set_valid = 1'b0;
        clr_all   = 1'b0;
        case (r_state)
            ahts_pkg::ST_SCAN: begin
                rd_en = (r_cnt != LAST_CNT);
            end
            ahts_pkg::ST_FETCH: begin
                rd_en   = 1'b1;
                rd_addr = pick_idx;
            end
            ahts_pkg::ST_DONE: begin
                case (r_kind)
                    ahts_pkg::KIND_ADD: begin
                        if (r_found) begin
                            res_stat      = ahts_pkg::STAT_HIT;
                            res_ent       = 1'b1;
                            res_data.hits = sat_hits;
                            res_data.tick = r_now;
                            wr_en         = leave_done;
                            wr_addr       = r_found_idx;
                            wr_data       = res_data;
                        end else if (r_free_ok) begin
                            res_stat  = ahts_pkg::STAT_INSERTED;
                            res_ent   = 1'b1;
                            res_data  = '{typ: r_typ, hi: r_hi, lo: r_lo,
                                          hits: 32'd1, tick: r_now};
                            wr_en     = leave_done;
                            wr_addr   = r_free_idx;
                            wr_data   = res_data;
                            set_valid = leave_done;
                        end else begin
                            res_stat = ahts_pkg::STAT_FULL;
                        end
                    end
                    ahts_pkg::KIND_LOOKUP: begin
                        res_stat = r_found ? ahts_pkg::STAT_FOUND : ahts_pkg::STAT_NOT_FOUND;
                        res_ent  = r_found;
                    end
                    ahts_pkg::KIND_SELECT: begin
                        // zero tick difference never counts as a late receive
                        if (!r_inhibit && (r_hit_ok && (r_max_hit > 32'd1) || r_late_ok)) begin
                            res_stat = ahts_pkg::STAT_SELECTED;
                            res_ent  = 1'b1;
                        end
                    end
                    default: begin
                        clr_all = leave_done;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ahts_pkg::ST_IDLE;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state <= n_state;
            if (clr_all) begin
                r_valid <= '0;
            end else if (set_valid) begin
                r_valid[r_free_idx] <= 1'b1;
            end
            if (leave_done) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (in_beat) begin
                r_cnt <= '0;
            end else if (r_state == ahts_pkg::ST_SCAN && r_cnt != LAST_CNT) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // item capture and scan trackers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_kind     <= i_s_tuser[1:0];
            r_typ      <= i_s_tuser[2];
            r_hi       <= i_s_tuser[2] ? i_s_tdata[63:0]
                                       : (i_s_tdata[63:0] & ahts_pkg::V4_HI_MASK);
            r_lo       <= i_s_tuser[2] ? i_s_tdata[127:64] : 64'd0;
            r_now      <= i_s_tdata[159:128];
            r_send     <= i_s_tdata[191:160];
            r_inhibit  <= i_s_tdata[192];
            r_found    <= 1'b0;
            r_free_ok  <= 1'b0;
            r_hit_ok   <= 1'b0;
            r_late_ok  <= 1'b0;
            r_max_hit  <= '0;
            r_max_diff <= '0;
        end else if (ev_on) begin
            if (ev_same && !r_found) begin
                r_found     <= 1'b1;
                r_found_idx <= ev_idx;
            end
            if (!ev_valid && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= ev_idx;
            end
            if (ev_match && ev_diff > r_max_diff) begin
                r_max_diff <= ev_diff;
                r_late_ok  <= 1'b1;
                r_late_idx <= ev_idx;
            end
            if (ev_match && r_rd_data.hits > r_max_hit) begin
                r_max_hit <= r_rd_data.hits;
                r_hit_ok  <= 1'b1;
                r_hit_idx <= ev_idx;
            end
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (leave_done) begin
            r_out_user <= res_stat;
            r_out_data <= res_ent ? {res_data.lo, res_data.hi, res_data.tick, res_data.hits}
                                  : '0;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LAST_CNT)
        else $error("scan counter past table end");

    a_fetch_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ahts_pkg::ST_FETCH) |-> (r_cnt == LAST_CNT))
        else $error("fetch before scan finished");

    a_insert_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        set_valid |-> !r_valid[r_free_idx])
        else $error("insert into occupied slot");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_all |=> (r_valid == '0))
        else $error("table not empty after clear");

    a_no_dup_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        set_valid |-> !r_found)
        else $error("insert of address already present");

endmodule
